// File: sv/vat_pkg.sv
// Package for the variant allele trimmer: item types, command codes and constants.
// Used by vat_front, vat_back and variant_allele_trimmer. No dependencies.
package vat_pkg;

    // Input command codes
    localparam logic [1:0] CMD_REF  = 2'd0;
    localparam logic [1:0] CMD_ALT  = 2'd1;
    localparam logic [1:0] CMD_TRIM = 2'd2;

    localparam logic [7:0]  STAR_BYTE = 8'h2A;
    localparam logic [30:0] POS_MAX   = 31'h7FFF_FFFF;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_REF  = 2'd0,
        OP_ALT  = 2'd1,
        OP_TRIM = 2'd2
    } op_t;

    // Input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  base;
        logic        begin_first;
        logic [30:0] start_pos;
        logic [30:0] end_pos;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [8:0]  prefix_trim;
        logic [8:0]  suffix_trim;
        logic [30:0] new_start;
        logic [30:0] new_end;
        logic [8:0]  new_length;
        logic        skipped;
        logic        overflow;
    } out_item_t;

    // Queue entry
    typedef struct packed {
        op_t         op;
        logic [7:0]  base;
        logic        begin_first;
        logic [30:0] start_pos;
        logic [30:0] end_pos;
    } vat_cmd_t;

endpackage

// File: sv/vat_front.sv
// Front end: accepts input items, decodes the command and queues valid ones.
// Depends on vat_pkg. Unused command codes are accepted and dropped here.
module vat_front
    import vat_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output vat_cmd_t q_item
);

    vat_cmd_t             q_mem [QDEPTH];
    logic [QPTR_W:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W:0]      rd_ptr_reg, rd_ptr_next;
    logic                 q_full, q_empty;
    logic                 keep;
    logic                 push, pop;
    vat_cmd_t             dec_item;

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_full  = (wr_ptr_reg[QPTR_W] != rd_ptr_reg[QPTR_W]) &&
                     (wr_ptr_reg[QPTR_W-1:0] == rd_ptr_reg[QPTR_W-1:0]);

    assign s_ready = !q_full;
    assign q_valid = !q_empty;
    assign q_item  = q_mem[rd_ptr_reg[QPTR_W-1:0]];

    // Decode the command; unknown codes are not queued
    always_comb begin
        keep                 = 1'b1;
        dec_item.op          = OP_REF;
        dec_item.base        = s_data.base;
        dec_item.begin_first = s_data.begin_first;
        dec_item.start_pos   = s_data.start_pos;
        dec_item.end_pos     = s_data.end_pos;
        case (s_data.cmd)
            CMD_REF:  dec_item.op = OP_REF;
            CMD_ALT:  dec_item.op = OP_ALT;
            CMD_TRIM: dec_item.op = OP_TRIM;
            default:  keep = 1'b0;
        endcase
    end

    assign push = s_valid && s_ready && keep;
    assign pop  = q_valid && q_ready;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg[QPTR_W-1:0]] <= dec_item;
        end
    end

endmodule

// File: sv/vat_back.sv
// Back end: sequence buffers, append execution, prefix/suffix trim walk, result register.
// Depends on vat_pkg. Buffers are single-port-read memories with registered read data.
module vat_back
    import vat_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  vat_cmd_t  q_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CNT_W  = $clog2(MAX_SEQ_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_SEQ_LEN);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEQ_LEN);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HREAD = 6'b000010,
        S_HCMP  = 6'b000100,
        S_TREAD = 6'b001000,
        S_TCMP  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    logic [7:0] ref_mem [MAX_SEQ_LEN];
    logic [7:0] alt_mem [MAX_SEQ_LEN];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ref_cnt_reg, ref_cnt_next;
    logic [CNT_W-1:0] alt_cnt_reg, alt_cnt_next;
    logic             dropped_reg, dropped_next;
    logic             star_reg, star_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic             bf_reg, bf_next;
    logic             skip_reg, skip_next;
    logic [30:0]      start_reg, start_next;
    logic [30:0]      end_reg, end_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg, out_next;
    logic [7:0]       ref_rd_reg, alt_rd_reg;

    logic              ref_we, alt_we;
    logic              rd_en;
    logic [ADDR_W-1:0] ref_raddr, alt_raddr;
    logic [CNT_W-1:0]  head_lim_a, head_lim_r;
    logic [CNT_W-1:0]  ref_tail_idx, alt_tail_idx;
    logic [CNT_W:0]    tail_sum;
    logic              head_go, tail_go, match;
    logic              out_load;
    logic [31:0]       ns_sum;
    logic [CNT_W-1:0]  len_rem;

    // Loop bounds: the head walk stops short of the trimmed suffix,
    // the tail walk stops short of the trimmed prefix
    assign head_lim_a   = alt_cnt_reg - s_reg;
    assign head_lim_r   = ref_cnt_reg - s_reg;
    assign head_go      = (n_reg < head_lim_a) && (n_reg < head_lim_r);
    assign tail_sum     = {1'b0, n_reg} + {1'b0, p_reg};
    assign tail_go      = (tail_sum < {1'b0, alt_cnt_reg}) &&
                          (tail_sum < {1'b0, ref_cnt_reg});
    assign alt_tail_idx = alt_cnt_reg - CNT_W'(1) - n_reg;
    assign ref_tail_idx = ref_cnt_reg - CNT_W'(1) - n_reg;
    assign match        = (alt_rd_reg == ref_rd_reg);

    // Read address and enable
    always_comb begin
        rd_en     = 1'b0;
        alt_raddr = n_reg[ADDR_W-1:0];
        ref_raddr = n_reg[ADDR_W-1:0];
        case (state_reg)
            S_HREAD: rd_en = head_go;
            S_TREAD: begin
                rd_en     = tail_go;
                alt_raddr = alt_tail_idx[ADDR_W-1:0];
                ref_raddr = ref_tail_idx[ADDR_W-1:0];
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Result fields
    assign ns_sum  = {1'b0, start_reg} + 32'(p_reg);
    assign len_rem = alt_cnt_reg - p_reg - s_reg;
    always_comb begin
        out_next.prefix_trim = 9'(p_reg);
        out_next.suffix_trim = 9'(s_reg);
        out_next.new_start   = ns_sum[31] ? POS_MAX : ns_sum[30:0];
        out_next.new_end     = (end_reg >= 31'(s_reg)) ? end_reg - 31'(s_reg) : 31'd0;
        out_next.new_length  = 9'(len_rem);
        out_next.skipped     = skip_reg;
        out_next.overflow    = dropped_reg;
    end

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign q_ready  = (state_reg == S_IDLE);

    // Control sequencer
    always_comb begin
        state_next   = state_reg;
        ref_cnt_next = ref_cnt_reg;
        alt_cnt_next = alt_cnt_reg;
        dropped_next = dropped_reg;
        star_next    = star_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        s_next       = s_reg;
        bf_next      = bf_reg;
        skip_next    = skip_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        ref_we       = 1'b0;
        alt_we       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.op)
                        OP_REF: begin
                            if (ref_cnt_reg < MAX_CNT) begin
                                ref_we       = 1'b1;
                                ref_cnt_next = ref_cnt_reg + 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_ALT: begin
                            if (alt_cnt_reg < MAX_CNT) begin
                                alt_we       = 1'b1;
                                alt_cnt_next = alt_cnt_reg + 1'b1;
                                if (alt_cnt_reg == '0) begin
                                    star_next = (q_item.base == STAR_BYTE);
                                end
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_TRIM: begin
                            bf_next    = q_item.begin_first;
                            start_next = q_item.start_pos;
                            end_next   = q_item.end_pos;
                            n_next     = '0;
                            p_next     = '0;
                            s_next     = '0;
                            skip_next  = (alt_cnt_reg == CNT_W'(1)) && star_reg;
                            if ((alt_cnt_reg == CNT_W'(1)) && star_reg) begin
                                state_next = S_DONE;
                            end else if (q_item.begin_first) begin
                                state_next = S_HREAD;
                            end else begin
                                state_next = S_TREAD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_HREAD, S_HCMP: begin
                if ((state_reg == S_HREAD) && head_go) begin
                    state_next = S_HCMP;
                end else if ((state_reg == S_HCMP) && match) begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_HREAD;
                end else begin
                    // common prefix found
                    p_next     = n_reg;
                    n_next     = '0;
                    state_next = bf_reg ? S_TREAD : S_DONE;
                end
            end
            S_TREAD, S_TCMP: begin
                if ((state_reg == S_TREAD) && tail_go) begin
                    state_next = S_TCMP;
                end else if ((state_reg == S_TCMP) && match) begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_TREAD;
                end else begin
                    // common suffix found
                    s_next     = n_reg;
                    n_next     = '0;
                    state_next = bf_reg ? S_DONE : S_HREAD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    ref_cnt_next = '0;
                    alt_cnt_next = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ref_cnt_reg <= '0;
            alt_cnt_reg <= '0;
            dropped_reg <= 1'b0;
            star_reg    <= 1'b0;
            n_reg       <= '0;
            p_reg       <= '0;
            s_reg       <= '0;
            bf_reg      <= 1'b0;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ref_cnt_reg <= ref_cnt_next;
            alt_cnt_reg <= alt_cnt_next;
            dropped_reg <= dropped_next;
            star_reg    <= star_next;
            n_reg       <= n_next;
            p_reg       <= p_next;
            s_reg       <= s_next;
            bf_reg      <= bf_next;
            skip_reg    <= skip_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // Sequence buffers
    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_cnt_reg[ADDR_W-1:0]] <= q_item.base;
        end
        if (alt_we) begin
            alt_mem[alt_cnt_reg[ADDR_W-1:0]] <= q_item.base;
        end
        if (rd_en) begin
            ref_rd_reg <= ref_mem[ref_raddr];
            alt_rd_reg <= alt_mem[alt_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ref_cnt_reg <= MAX_CNT) && (alt_cnt_reg <= MAX_CNT))
        else $error("buffer count beyond capacity");

    a_hcmp_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HCMP) |-> ($past(state_reg) == S_HREAD))
        else $error("head compare without a read");

    a_tcmp_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TCMP) |-> ($past(state_reg) == S_TREAD))
        else $error("tail compare without a read");

    a_skip_no_trim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.skipped) |->
            ((out_reg.prefix_trim == 9'd0) && (out_reg.suffix_trim == 9'd0)))
        else $error("skipped allele reports a trim");

    a_clear_after_trim: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ((ref_cnt_reg == '0) && (alt_cnt_reg == '0) && !dropped_reg))
        else $error("buffers not emptied after trim");

endmodule

// File: sv/variant_allele_trimmer.sv
// Appends: one item per cycle while the back end is idle and the 4-entry queue is not full;
// each passes the queue, then the back end writes it to its buffer or, if full, sets overflow.
// Trim: the head and tail walks read and compare base pairs in turn; a star allele skips both.
// A finished result waits in an output register while later appends keep flowing.
// Reset (aresetn, synchronous): queue, counts, flags and handshakes clear; buffer bytes
// are not cleared and need no clearing pass.
module variant_allele_trimmer
    import vat_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic     q_valid;
    logic     q_ready;
    vat_cmd_t q_item;

    // Decode and queue
    vat_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // Buffers and trim engine
    vat_back #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
